>>> hw/rtl/aitp_pkg.sv
// aitp_pkg: shared types, constants and helper functions for the integer token parser
// no dependencies; imported by ascii_integer_token_parser_top
`default_nettype none

package aitp_pkg;

    localparam int unsigned MAX_TOKEN_CHARS = 255;
    localparam int unsigned TOK_LEN_W       = $clog2(MAX_TOKEN_CHARS + 1);

    localparam int unsigned CH_W    = 8;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned BASE_W  = 5;
    localparam int unsigned SIZE_W  = 2;
    localparam int unsigned CFG_W   = 5;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUMBER_BASE = 1'b0,
        CFG_SIZE_CODE   = 1'b1
    } t_cfg_idx;

    typedef enum logic [SIZE_W-1:0] {
        SIZE_8  = 2'd0,
        SIZE_16 = 2'd1,
        SIZE_32 = 2'd2,
        SIZE_64 = 2'd3
    } t_size_code;

    localparam logic [CH_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CH_W-1:0] CHAR_PLUS  = 8'h2b;
    localparam logic [CH_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CHAR_CR    = 8'h0d;
    localparam logic [CH_W-1:0] DIGIT_NONE = 8'hff;

    function automatic logic is_blank(input logic [CH_W-1:0] c);
        return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
    endfunction

    function automatic logic [CH_W-1:0] digit_of(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] d;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            d = c - 8'h30;
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            d = c - 8'h57;
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            d = c - 8'h37;
        end else begin
            d = DIGIT_NONE;
        end
        return d;
    endfunction

    // shift-add product, truncated to the value width
    function automatic logic [VALUE_W-1:0] mul_base(input logic [VALUE_W-1:0] acc,
                                                    input logic [BASE_W-1:0]  base);
        logic [VALUE_W-1:0] sum;
        sum = '0;
        for (int k = 0; k < BASE_W; k++) begin
            if (base[k]) begin
                sum = sum + (acc << k);
            end
        end
        return sum;
    endfunction

    function automatic logic [VALUE_W-1:0] size_mask(input t_size_code sz);
        logic [VALUE_W-1:0] m;
        unique case (sz)
            SIZE_8:  m = VALUE_W'(64'h0000_0000_0000_00ff);
            SIZE_16: m = VALUE_W'(64'h0000_0000_0000_ffff);
            SIZE_32: m = VALUE_W'(64'h0000_0000_ffff_ffff);
            SIZE_64: m = '1;
            default: m = '1;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ascii_integer_token_parser_top.sv
// ascii_integer_token_parser_top: a beat is taken into the input register, and its result
// goes from the processing stage into the output register; one character beat is accepted
// every cycle when not stalled; accumulate (multiply by base plus digit) is combinational.
// a stalled result holds the processing stage; the input register takes no new beat then.
// synchronous active-low reset clears handshake state, token state and config to defaults.
// depends on aitp_pkg
`default_nettype none

module ascii_integer_token_parser_top
    import aitp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // config write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // character input
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [CH_W-1:0]      i_ch,
    input  wire logic                 i_end_of_input,
    // result output
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [VALUE_W-1:0]        o_parsed_value,
    output logic                      o_status
);

    // config
    logic [BASE_W-1:0] r_base;
    t_size_code        r_size;

    // input register
    logic              r_in_valid;
    logic [CH_W-1:0]   r_ch;
    logic              r_eoi;

    // token state
    logic                 r_in_tok, n_in_tok;
    logic [VALUE_W-1:0]   r_acc, n_acc;
    logic                 r_neg, n_neg;
    logic                 r_stopped, n_stopped;
    logic [TOK_LEN_W-1:0] r_tok_len, n_tok_len;

    // output register
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_value, n_value;
    logic               r_status, n_status;

    logic               advance;
    logic               in_take;
    logic               emit;
    logic [CH_W-1:0]    digit;
    logic               digit_ok;
    logic               first_sign;
    logic [VALUE_W-1:0] acc_next;
    logic [VALUE_W-1:0] signed_val;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign digit      = digit_of(r_ch);
    assign digit_ok   = digit < {{(CH_W-BASE_W){1'b0}}, r_base};
    assign first_sign = (r_ch == CHAR_MINUS) || (r_ch == CHAR_PLUS);
    assign acc_next   = mul_base(r_acc, r_base) + {{(VALUE_W-CH_W){1'b0}}, digit};
    assign signed_val = r_neg ? (VALUE_W'(0) - r_acc) : r_acc;

    always_comb begin
        n_in_tok  = r_in_tok;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_stopped = r_stopped;
        n_tok_len = r_tok_len;
        n_value   = '0;
        n_status  = 1'b0;
        emit      = 1'b0;
        if (advance) begin
            if (!r_in_tok) begin
                if (r_eoi) begin
                    emit     = 1'b1;
                    n_status = 1'b1;
                end else if (!is_blank(r_ch)) begin
                    n_in_tok  = 1'b1;
                    n_tok_len = TOK_LEN_W'(1);
                    if (r_ch == CHAR_MINUS) begin
                        n_neg = 1'b1;
                    end else if (!first_sign) begin
                        if (digit_ok) begin
                            n_acc = acc_next;
                        end else begin
                            n_stopped = 1'b1;
                        end
                    end
                end
            end else if (r_eoi || is_blank(r_ch)
                         || (r_tok_len >= TOK_LEN_W'(MAX_TOKEN_CHARS))) begin
                emit      = 1'b1;
                n_value   = signed_val & size_mask(r_size);
                n_in_tok  = 1'b0;
                n_acc     = '0;
                n_neg     = 1'b0;
                n_stopped = 1'b0;
                n_tok_len = '0;
            end else begin
                n_tok_len = r_tok_len + TOK_LEN_W'(1);
                if (!r_stopped) begin
                    if (digit_ok) begin
                        n_acc = acc_next;
                    end else begin
                        n_stopped = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
            r_size <= SIZE_32;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NUMBER_BASE: r_base <= i_cfg_data[BASE_W-1:0];
                CFG_SIZE_CODE:   r_size <= t_size_code'(i_cfg_data[SIZE_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ch  <= i_ch;
            r_eoi <= i_end_of_input;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tok  <= 1'b0;
            r_acc     <= '0;
            r_neg     <= 1'b0;
            r_stopped <= 1'b0;
            r_tok_len <= '0;
        end else begin
            r_in_tok  <= n_in_tok;
            r_acc     <= n_acc;
            r_neg     <= n_neg;
            r_stopped <= n_stopped;
            r_tok_len <= n_tok_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_parsed_value = r_value;
    assign o_status       = r_status;

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok_len <= TOK_LEN_W'(MAX_TOKEN_CHARS))
        else $error("token length beyond limit");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_tok |-> (r_acc == '0 && !r_neg && !r_stopped && r_tok_len == '0))
        else $error("token state not cleared outside a token");

    a_no_token_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_parsed_value == '0))
        else $error("no-token result carries a value");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !advance)
        else $error("stage advanced into an occupied output");
`endif

endmodule

`default_nettype wire
